// ===== rtl/lar_pkg.sv =====
// Shared constants, types and helpers of the anti-aliased line rasteriser.
package lar_pkg;

   localparam int LAR_SCREEN_WIDTH  = 256;
   localparam int LAR_SCREEN_HEIGHT = 128;
   localparam int LAR_DIV_STEPS     = 17;
   localparam int LAR_CNT_W         = $clog2(LAR_DIV_STEPS);

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_STEP = 1'b1
   } lar_op_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_CAPTURE,
      CMD_PREP,
      CMD_ORDER,
      CMD_SETUP,
      CMD_DIV,
      CMD_SLOPE,
      CMD_MUL,
      CMD_ENDS,
      CMD_WGT,
      CMD_COMMIT,
      CMD_EMIT0,
      CMD_EMIT1
   } lar_cmd_type;

   typedef struct packed {
      logic line_active;
      logic div_last;
   } lar_status_type;

   // floor(b * 15 / 256) for b in 0..256
   function automatic logic [3:0] lum_of(input logic [8:0] b);
      logic [12:0] p;
      p = {b, 4'b0} - {4'b0, b};
      return p[11:8];
   endfunction

endpackage

// ===== rtl/lar_ctrl.sv =====
// Sequencer of the rasteriser: line set-up steps and the two-pixel column emission.
module lar_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_op,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  lar_pkg::lar_status_type status,
   output lar_pkg::lar_cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_ORDER,
      ST_SETUP,
      ST_DIV,
      ST_SLOPE,
      ST_MUL,
      ST_ENDS,
      ST_WGT,
      ST_COMMIT,
      ST_EMIT0,
      ST_EMIT1
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      can_load;

   assign can_load  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = lar_pkg::CMD_NONE;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_op == lar_pkg::OP_LOAD) begin
                  cmd      = lar_pkg::CMD_CAPTURE;
                  state_in = ST_PREP;
               end else if (status.line_active) begin
                  state_in = ST_EMIT0;
               end
            end
         end
         ST_PREP: begin
            cmd      = lar_pkg::CMD_PREP;
            state_in = ST_ORDER;
         end
         ST_ORDER: begin
            cmd      = lar_pkg::CMD_ORDER;
            state_in = ST_SETUP;
         end
         ST_SETUP: begin
            cmd      = lar_pkg::CMD_SETUP;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd = lar_pkg::CMD_DIV;
            if (status.div_last) state_in = ST_SLOPE;
         end
         ST_SLOPE: begin
            cmd      = lar_pkg::CMD_SLOPE;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd      = lar_pkg::CMD_MUL;
            state_in = ST_ENDS;
         end
         ST_ENDS: begin
            cmd      = lar_pkg::CMD_ENDS;
            state_in = ST_WGT;
         end
         ST_WGT: begin
            cmd      = lar_pkg::CMD_WGT;
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            cmd      = lar_pkg::CMD_COMMIT;
            state_in = ST_IDLE;
         end
         ST_EMIT0: begin
            if (can_load) begin
               cmd          = lar_pkg::CMD_EMIT0;
               rsp_valid_in = 1'b1;
               state_in     = ST_EMIT1;
            end
         end
         ST_EMIT1: begin
            if (can_load) begin
               cmd          = lar_pkg::CMD_EMIT1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/lar_dp.sv =====
// Datapath of the rasteriser: set-up arithmetic, slope divider, column state, pixel register.
module lar_dp #(
   parameter int SCREEN_WIDTH  = lar_pkg::LAR_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = lar_pkg::LAR_SCREEN_HEIGHT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lar_pkg::lar_cmd_type  cmd,
   output lar_pkg::lar_status_type status,
   input  logic signed [15:0]    req_start_x,
   input  logic signed [15:0]    req_start_y,
   input  logic signed [15:0]    req_end_x,
   input  logic signed [15:0]    req_end_y,
   input  logic [7:0]            req_color,
   output logic [7:0]            rsp_pixel_x,
   output logic [6:0]            rsp_pixel_y,
   output logic [3:0]            rsp_lum_index,
   output logic [7:0]            rsp_pixel_color,
   output logic                  rsp_visible,
   output logic                  rsp_line_last
);

   logic signed [15:0] x0_ff, y0_ff, x1_ff, y1_ff;
   logic [7:0]         color_ff;
   logic               steep_ff;
   logic [15:0]        dx_ff;
   logic               dy_neg_ff;
   logic [15:0]        rem_ff;
   logic [16:0]        quo_ff;
   logic [lar_pkg::LAR_CNT_W-1:0] cnt_ff;
   logic signed [11:0] xe1_ff, xe2_ff;
   logic [6:0]         gap1_ff, gap2_ff;
   logic signed [17:0] slope_ff;
   logic signed [18:0] off1_ff, off2_ff;
   logic signed [36:0] prod1_ff, prod2_ff;
   logic signed [27:0] ye1_ff, ye2_ff;
   logic [8:0]         b1lo_ff, b1hi_ff, b2lo_ff, b2hi_ff;
   logic signed [11:0] row1_ff, row2_ff;
   logic [7:0]         w1_ff, w2_ff;
   logic signed [27:0] ycross_ff;
   logic signed [11:0] col_now_ff;
   logic               active_ff;

   logic [7:0]  pix_x_ff;
   logic [6:0]  pix_y_ff;
   logic [3:0]  lum_ff;
   logic [7:0]  pcol_ff;
   logic        vis_ff;
   logic        last_ff;

   // prep / order
   logic signed [16:0] ddx, ddy;
   logic [16:0]        adx, ady;
   logic signed [15:0] sx0, sy0, sx1, sy1;
   // setup
   logic signed [16:0] sdx, sdy, sum0, sum1;
   logic [16:0]        mdy;
   // divider
   logic [16:0]        trial;
   logic               ge;
   // weights
   logic [16:0]        inv1, inv2;
   logic [23:0]        p1lo, p1hi, p2lo, p2hi;
   // commit
   logic [3:0]         l1lo, l1hi, l2lo, l2hi;
   // emission
   logic               is_first, is_final, is_inner, last;
   logic signed [11:0] row;
   logic [3:0]         lo, hi;
   logic [16:0]        inv_c;
   logic signed [12:0] minor, major, px, py;
   logic               vis;
   logic [3:0]         lum_sel;

   assign status.line_active = active_ff;
   assign status.div_last    = (cnt_ff == lar_pkg::LAR_CNT_W'(lar_pkg::LAR_DIV_STEPS - 1));

   always_comb begin
      ddx = 17'(x1_ff) - 17'(x0_ff);
      ddy = 17'(y1_ff) - 17'(y0_ff);
      adx = ddx[16] ? 17'(-ddx) : 17'(ddx);
      ady = ddy[16] ? 17'(-ddy) : 17'(ddy);

      sx0 = steep_ff ? y0_ff : x0_ff;
      sy0 = steep_ff ? x0_ff : y0_ff;
      sx1 = steep_ff ? y1_ff : x1_ff;
      sy1 = steep_ff ? x1_ff : y1_ff;

      sdx  = 17'(x1_ff) - 17'(x0_ff);
      sdy  = 17'(y1_ff) - 17'(y0_ff);
      mdy  = sdy[16] ? 17'(-sdy) : 17'(sdy);
      sum0 = 17'(x0_ff) + 17'sd32;
      sum1 = 17'(x1_ff) + 17'sd32;

      trial = {rem_ff, quo_ff[16]};
      ge    = trial >= {1'b0, dx_ff};

      inv1 = 17'h10000 - {1'b0, ye1_ff[15:0]};
      inv2 = 17'h10000 - {1'b0, ye2_ff[15:0]};
      p1lo = 24'(inv1) * 24'(gap1_ff);
      p1hi = 24'(ye1_ff[15:0]) * 24'(gap1_ff);
      p2lo = 24'(inv2) * 24'(gap2_ff);
      p2hi = 24'(ye2_ff[15:0]) * 24'(gap2_ff);

      l1lo = lar_pkg::lum_of(b1lo_ff);
      l1hi = lar_pkg::lum_of(b1hi_ff);
      l2lo = lar_pkg::lum_of(b2lo_ff);
      l2hi = lar_pkg::lum_of(b2hi_ff);
   end

   // pixels of the current column
   always_comb begin
      is_first = (col_now_ff == xe1_ff);
      is_final = (col_now_ff >= xe2_ff);
      is_inner = !is_first && !is_final;
      inv_c    = 17'h10000 - {1'b0, ycross_ff[15:0]};
      if (is_first) begin
         row  = row1_ff;
         lo   = w1_ff[3:0];
         hi   = w1_ff[7:4];
         last = (col_now_ff == xe2_ff);
      end else if (is_final) begin
         row  = row2_ff;
         lo   = w2_ff[3:0];
         hi   = w2_ff[7:4];
         last = 1'b1;
      end else begin
         row  = ycross_ff[27:16];
         lo   = lar_pkg::lum_of(inv_c[16:8]);
         hi   = lar_pkg::lum_of({1'b0, ycross_ff[15:8]});
         last = 1'b0;
      end
      minor   = (cmd == lar_pkg::CMD_EMIT1) ? 13'(row) + 13'sd1 : 13'(row);
      lum_sel = (cmd == lar_pkg::CMD_EMIT1) ? hi : lo;
      major   = 13'(col_now_ff);
      px      = steep_ff ? minor : major;
      py      = steep_ff ? major : minor;
      vis     = !px[12] && !py[12]
                && ($signed({px[12], px}) < $signed(14'(SCREEN_WIDTH)))
                && ($signed({py[12], py}) < $signed(14'(SCREEN_HEIGHT)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         case (cmd)
            lar_pkg::CMD_CAPTURE: active_ff <= 1'b0;
            lar_pkg::CMD_COMMIT:  active_ff <= 1'b1;
            lar_pkg::CMD_EMIT1:   if (last) active_ff <= 1'b0;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd)
         lar_pkg::CMD_CAPTURE: begin
            x0_ff    <= req_start_x;
            y0_ff    <= req_start_y;
            x1_ff    <= req_end_x;
            y1_ff    <= req_end_y;
            color_ff <= req_color;
         end
         lar_pkg::CMD_PREP: steep_ff <= ady > adx;
         lar_pkg::CMD_ORDER: begin
            // swap axes for steep lines, then order along the major axis
            if (sx0 > sx1) begin
               x0_ff <= sx1;
               y0_ff <= sy1;
               x1_ff <= sx0;
               y1_ff <= sy0;
            end else begin
               x0_ff <= sx0;
               y0_ff <= sy0;
               x1_ff <= sx1;
               y1_ff <= sy1;
            end
         end
         lar_pkg::CMD_SETUP: begin
            dx_ff     <= sdx[15:0];
            dy_neg_ff <= sdy[16];
            rem_ff    <= {1'b0, mdy[15:1]};
            quo_ff    <= {mdy[0], 16'b0};
            cnt_ff    <= '0;
            xe1_ff    <= 12'(sum0 >>> 6);
            xe2_ff    <= 12'(sum1 >>> 6);
            gap1_ff   <= 7'd64 - {1'b0, sum0[5:0]};
            gap2_ff   <= {1'b0, sum1[5:0]};
         end
         lar_pkg::CMD_DIV: begin
            rem_ff <= ge ? 16'(trial - {1'b0, dx_ff}) : trial[15:0];
            quo_ff <= {quo_ff[15:0], ge};
            cnt_ff <= cnt_ff + 1'b1;
         end
         lar_pkg::CMD_SLOPE: begin
            if (dx_ff == '0) slope_ff <= 18'sd65536;
            else if (dy_neg_ff) slope_ff <= -$signed({1'b0, quo_ff});
            else slope_ff <= $signed({1'b0, quo_ff});
            off1_ff <= $signed({xe1_ff, 6'b0}) - 19'(x0_ff);
            off2_ff <= $signed({xe2_ff, 6'b0}) - 19'(x0_ff);
         end
         lar_pkg::CMD_MUL: begin
            prod1_ff <= 37'(slope_ff) * 37'(off1_ff);
            prod2_ff <= 37'(slope_ff) * 37'(off2_ff);
         end
         lar_pkg::CMD_ENDS: begin
            ye1_ff <= $signed({{2{y0_ff[15]}}, y0_ff, 10'b0}) + $signed(prod1_ff[33:6]);
            ye2_ff <= $signed({{2{y0_ff[15]}}, y0_ff, 10'b0}) + $signed(prod2_ff[33:6]);
         end
         lar_pkg::CMD_WGT: begin
            b1lo_ff   <= p1lo[22:14];
            b1hi_ff   <= p1hi[22:14];
            b2lo_ff   <= p2lo[22:14];
            b2hi_ff   <= p2hi[22:14];
            row1_ff   <= ye1_ff[27:16];
            row2_ff   <= ye2_ff[27:16];
            ycross_ff <= ye1_ff + 28'(slope_ff);
         end
         lar_pkg::CMD_COMMIT: begin
            // coinciding endpoint columns take the larger weight per row
            if (xe1_ff == xe2_ff) begin
               w1_ff <= {(l2hi > l1hi) ? l2hi : l1hi, (l2lo > l1lo) ? l2lo : l1lo};
            end else begin
               w1_ff <= {l1hi, l1lo};
            end
            w2_ff      <= {l2hi, l2lo};
            col_now_ff <= xe1_ff;
         end
         lar_pkg::CMD_EMIT1: begin
            if (!last) col_now_ff <= col_now_ff + 12'sd1;
            if (is_inner) ycross_ff <= ycross_ff + 28'(slope_ff);
         end
         default: ;
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd == lar_pkg::CMD_EMIT0 || cmd == lar_pkg::CMD_EMIT1) begin
         pix_x_ff <= vis ? px[7:0] : 8'd0;
         pix_y_ff <= vis ? py[6:0] : 7'd0;
         lum_ff   <= vis ? lum_sel : 4'd0;
         pcol_ff  <= vis ? color_ff : 8'd0;
         vis_ff   <= vis;
         last_ff  <= (cmd == lar_pkg::CMD_EMIT1) && last;
      end
   end

   assign rsp_pixel_x     = pix_x_ff;
   assign rsp_pixel_y     = pix_y_ff;
   assign rsp_lum_index   = lum_ff;
   assign rsp_pixel_color = pcol_ff;
   assign rsp_visible     = vis_ff;
   assign rsp_line_last   = last_ff;

endmodule

// ===== rtl/antialiased_line_raster.sv =====
// Top level of the anti-aliased line rasteriser: sequencer plus datapath.
// Load: prep, order, set-up, slope divider (one quotient bit per cycle), slope,
// multiply, ends, weights and commit run before the next transfer is taken.
// Step: two results, one per cycle when the result side is ready, or none if no
// line is active; the next request is taken once both results are loaded.
// Synchronous active-high reset idles the sequencer, clears the active line
// and empties the result register.
module antialiased_line_raster #(
   parameter int SCREEN_WIDTH  = lar_pkg::LAR_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = lar_pkg::LAR_SCREEN_HEIGHT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_op,
   input  logic signed [15:0] req_start_x,
   input  logic signed [15:0] req_start_y,
   input  logic signed [15:0] req_end_x,
   input  logic signed [15:0] req_end_y,
   input  logic [7:0]         req_color,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_pixel_x,
   output logic [6:0]         rsp_pixel_y,
   output logic [3:0]         rsp_lum_index,
   output logic [7:0]         rsp_pixel_color,
   output logic               rsp_visible,
   output logic               rsp_line_last
);

   lar_pkg::lar_cmd_type    cmd;
   lar_pkg::lar_status_type status;

   lar_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_op),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lar_dp #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_start_x     (req_start_x),
      .req_start_y     (req_start_y),
      .req_end_x       (req_end_x),
      .req_end_y       (req_end_y),
      .req_color       (req_color),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_lum_index   (rsp_lum_index),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_visible     (rsp_visible),
      .rsp_line_last   (rsp_line_last)
   );

endmodule

// ===== rtl/lar_checker.sv =====
// Port-level checks of the rasteriser and their binding to the top level.
module lar_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_pixel_x,
   input logic [6:0] rsp_pixel_y,
   input logic [3:0] rsp_lum_index,
   input logic [7:0] rsp_pixel_color,
   input logic       rsp_visible,
   input logic       rsp_line_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before transfer");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable({rsp_pixel_x, rsp_pixel_y, rsp_lum_index,
                                           rsp_pixel_color, rsp_visible, rsp_line_last}))
      else $error("stalled result changed");

   a_clip_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_visible |-> rsp_pixel_x == 8'd0 && rsp_pixel_y == 7'd0
                                    && rsp_lum_index == 4'd0 && rsp_pixel_color == 8'd0)
      else $error("clipped pixel carries data");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("reset left result pending or block busy");

endmodule

bind antialiased_line_raster lar_checker u_lar_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_pixel_x     (rsp_pixel_x),
   .rsp_pixel_y     (rsp_pixel_y),
   .rsp_lum_index   (rsp_lum_index),
   .rsp_pixel_color (rsp_pixel_color),
   .rsp_visible     (rsp_visible),
   .rsp_line_last   (rsp_line_last)
);
